[sv/ddo_pkg.sv]
// Package for the differential-drive odometry and speed loop core.
// Holds operand widths, gains, direction codes and the CORDIC angle table.
// No dependencies.
package ddo_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int DUTY_LIMIT   = 100;
    localparam int CORDIC_N     = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int MCNT_W = $clog2(MUL_W);
    localparam int CC_W   = 6;
    localparam int CMD_W  = 49;
    localparam int LIM_W  = 27;
    localparam int ERR_W  = 33;
    localparam int DCNT_W = $clog2(LIM_W + 1);
    localparam int REM_W  = 7;

    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
    localparam logic [REM_W:0] PCT_SCALE = 8'd100;
    localparam logic [CMD_W-1:0] LIM_CMD = CMD_W'(DUTY_LIMIT * 65536);

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    localparam logic [2:0] REG_DIST   = 3'd0;
    localparam logic [2:0] REG_ANGLE  = 3'd1;
    localparam logic [2:0] REG_RPM    = 3'd2;
    localparam logic [2:0] REG_GAIN   = 3'd3;
    localparam logic [2:0] REG_PERIOD = 3'd4;

    typedef logic signed [MUL_W-1:0] t_mop;

    function automatic logic [MUL_W-1:0] atan_at(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return {{(MUL_W-30){1'b0}}, v};
    endfunction

endpackage

[sv/diff_drive_odometry_speed_loop_core.sv]
// Differential-drive odometry with proportional wheel-speed control.
// Each input transaction runs five passes of two 34-bit bit-serial multipliers
// (CORDIC overlapped) and a restoring divide by 100; a new transaction is accepted
// only after the previous result has been issued.
// Reset (synchronous, active low) clears pose and heading and loads register defaults.
// Depends on ddo_pkg and ddo_serial_mul.
module diff_drive_odometry_speed_loop_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [15:0]  i_left_count,
    input  logic signed [15:0]  i_right_count,
    input  logic signed [23:0]  i_left_target,
    input  logic signed [23:0]  i_right_target,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_pose_x,
    output logic signed [31:0]  o_pose_y,
    output logic [31:0]         o_heading,
    output logic [15:0]         o_left_duty,
    output logic [15:0]         o_right_duty,
    output logic [1:0]          o_left_dir,
    output logic [1:0]          o_right_dir
);
    import ddo_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LAUNCH = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    localparam logic [2:0] PH_ODO  = 3'd0;
    localparam logic [2:0] PH_RPM  = 3'd1;
    localparam logic [2:0] PH_XY   = 3'd2;
    localparam logic [2:0] PH_GAIN = 3'd3;
    localparam logic [2:0] PH_PER  = 3'd4;

    logic [2:0]        r_state;
    logic [2:0]        r_phase;
    logic [CC_W-1:0]   r_ccnt;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_ovalid;

    logic [23:0] r_dist, r_angle;
    logic [15:0] r_rpm, r_gain, r_period;
    logic [31:0] r_px, r_py, r_head;

    logic signed [15:0] r_nl, r_nr;
    logic signed [23:0] r_tl, r_tr;
    logic [31:0]        r_d;
    logic signed [MUL_W-1:0] r_cx, r_cy, r_cz;
    logic [1:0]         r_q;
    logic [ERR_W-1:0]   r_err [2];
    logic [LIM_W-1:0]   r_mag [2];
    logic [LIM_W-1:0]   r_dv  [2];
    logic [REM_W-1:0]   r_rem [2];

    logic signed [31:0] r_o_x, r_o_y;
    logic [31:0]        r_o_head;
    logic [15:0]        r_o_duty [2];
    logic [1:0]         r_o_dir  [2];

    logic              w_start;
    t_mop              w_a0, w_b0, w_a1, w_b1;
    logic              w_busy0, w_busy1;
    logic [PROD_W-1:0] w_p [2];
    logic              w_cdone;
    logic              w_phase_end;
    logic              w_out_free;

    logic [16:0]  w_diff, w_sum;
    logic [31:0]  w_mid, w_qt, w_z32;
    logic [41:0]  w_dsum;
    logic [61:0]  w_xr, w_yr;
    logic signed [MUL_W-1:0] w_c, w_s, w_xs, w_ys, w_atan;
    logic signed [23:0] w_t [2];
    logic [ERR_W-1:0]   w_err [2];
    logic [CMD_W-1:0]   w_cmd [2];
    logic [CMD_W-1:0]   w_abs [2];
    logic [LIM_W-1:0]   w_mag [2];
    logic [REM_W:0]     w_rsh [2];
    logic               w_ge  [2];

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_start     = (r_state == ST_LAUNCH);
    assign w_cdone     = (r_ccnt == CC_W'(CORDIC_N));
    assign w_phase_end = (r_state == ST_MUL) && !w_busy0 && !w_busy1 && w_cdone;
    assign w_out_free  = !r_ovalid || i_out_ready;

    assign w_diff = {r_nl[15], r_nl} - {r_nr[15], r_nr};
    assign w_sum  = {r_nl[15], r_nl} + {r_nr[15], r_nr};
    assign w_t[0] = r_tl;
    assign w_t[1] = r_tr;

    always_comb begin
        unique case (r_q)
            2'd0: begin w_c = r_cx;  w_s = r_cy;  end
            2'd1: begin w_c = -r_cy; w_s = r_cx;  end
            2'd2: begin w_c = -r_cx; w_s = -r_cy; end
            default: begin w_c = r_cy; w_s = -r_cx; end
        endcase
    end

    always_comb begin
        unique case (r_phase)
            PH_ODO: begin
                w_a0 = {{(MUL_W-24){1'b0}}, r_angle};
                w_b0 = {{(MUL_W-17){w_diff[16]}}, w_diff};
                w_a1 = {{(MUL_W-24){1'b0}}, r_dist};
                w_b1 = {{(MUL_W-17){w_sum[16]}}, w_sum};
            end
            PH_RPM: begin
                w_a0 = {{(MUL_W-16){1'b0}}, r_rpm};
                w_b0 = {{(MUL_W-16){r_nl[15]}}, r_nl};
                w_a1 = {{(MUL_W-16){1'b0}}, r_rpm};
                w_b1 = {{(MUL_W-16){r_nr[15]}}, r_nr};
            end
            PH_XY: begin
                w_a0 = {{(MUL_W-32){r_d[31]}}, r_d};
                w_b0 = w_c;
                w_a1 = {{(MUL_W-32){r_d[31]}}, r_d};
                w_b1 = w_s;
            end
            PH_GAIN: begin
                w_a0 = {{(MUL_W-16){1'b0}}, r_gain};
                w_b0 = {{(MUL_W-ERR_W){r_err[0][ERR_W-1]}}, r_err[0]};
                w_a1 = {{(MUL_W-16){1'b0}}, r_gain};
                w_b1 = {{(MUL_W-ERR_W){r_err[1][ERR_W-1]}}, r_err[1]};
            end
            default: begin
                w_a0 = {{(MUL_W-16){1'b0}}, r_period};
                w_b0 = {{(MUL_W-LIM_W){1'b0}}, r_mag[0]};
                w_a1 = {{(MUL_W-16){1'b0}}, r_period};
                w_b1 = {{(MUL_W-LIM_W){1'b0}}, r_mag[1]};
            end
        endcase
    end

    ddo_serial_mul u_mul0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_a0),
        .i_b     (w_b0),
        .o_busy  (w_busy0),
        .o_prod  (w_p[0])
    );

    ddo_serial_mul u_mul1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_a1),
        .i_b     (w_b1),
        .o_busy  (w_busy1),
        .o_prod  (w_p[1])
    );

    assign w_mid  = r_head + w_p[0][32:1];
    assign w_qt   = w_mid + 32'h2000_0000;
    assign w_z32  = w_mid - {w_qt[31:30], 30'd0};
    assign w_dsum = w_p[1][41:0] + 42'd256;
    assign w_xr   = w_p[0][61:0] + 62'h2000_0000;
    assign w_yr   = w_p[1][61:0] + 62'h2000_0000;

    assign w_xs   = r_cx >>> r_ccnt;
    assign w_ys   = r_cy >>> r_ccnt;
    assign w_atan = atan_at(r_ccnt[4:0]);

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_err[k] = {{(ERR_W-24){w_t[k][23]}}, w_t[k]}
                     - {w_p[k][31], w_p[k][31:0]};
            w_cmd[k] = w_p[k][CMD_W-1:0];
            w_abs[k] = w_cmd[k][CMD_W-1] ? -w_cmd[k] : w_cmd[k];
            w_mag[k] = (w_abs[k] > LIM_CMD) ? LIM_CMD[LIM_W-1:0] : w_abs[k][LIM_W-1:0];
            w_rsh[k] = {r_rem[k], r_dv[k][LIM_W-1]};
            w_ge[k]  = (w_rsh[k] >= PCT_SCALE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_ODO;
            r_ccnt   <= CC_W'(CORDIC_N);
            r_dcnt   <= '0;
            r_ovalid <= 1'b0;
            r_px     <= '0;
            r_py     <= '0;
            r_head   <= '0;
            r_dist   <= 24'd40786;
            r_angle  <= 24'd103535;
            r_rpm    <= 16'd2612;
            r_gain   <= 16'd2560;
            r_period <= 16'd1000;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_DIST:   r_dist   <= i_cfg_data;
                    REG_ANGLE:  r_angle  <= i_cfg_data;
                    REG_RPM:    r_rpm    <= i_cfg_data[15:0];
                    REG_GAIN:   r_gain   <= i_cfg_data[15:0];
                    REG_PERIOD: r_period <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_out_ready && r_state != ST_DONE) begin
                r_ovalid <= 1'b0;
            end
            if (!w_cdone) begin
                r_ccnt <= r_ccnt + CC_W'(1);
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_phase <= PH_ODO;
                        r_state <= ST_LAUNCH;
                    end
                end
                ST_LAUNCH: begin
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    if (w_phase_end) begin
                        if (r_phase == PH_ODO) begin
                            r_head <= r_head + w_p[0][31:0];
                            r_ccnt <= '0;
                        end
                        if (r_phase == PH_XY) begin
                            r_px <= r_px + w_xr[61:30];
                            r_py <= r_py + w_yr[61:30];
                        end
                        if (r_phase == PH_PER) begin
                            r_dcnt  <= '0;
                            r_state <= ST_DIV;
                        end else begin
                            r_phase <= r_phase + 3'd1;
                            r_state <= ST_LAUNCH;
                        end
                    end
                end
                ST_DIV: begin
                    r_dcnt <= r_dcnt + DCNT_W'(1);
                    if (r_dcnt == DCNT_W'(LIM_W - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_nl <= i_left_count;
            r_nr <= i_right_count;
            r_tl <= i_left_target;
            r_tr <= i_right_target;
        end
        if (!w_cdone) begin
            if (!r_cz[MUL_W-1]) begin
                r_cx <= r_cx - w_ys;
                r_cy <= r_cy + w_xs;
                r_cz <= r_cz - w_atan;
            end else begin
                r_cx <= r_cx + w_ys;
                r_cy <= r_cy - w_xs;
                r_cz <= r_cz + w_atan;
            end
        end
        if (w_phase_end) begin
            unique case (r_phase)
                PH_ODO: begin
                    r_d  <= w_dsum[40:9];
                    r_q  <= w_qt[31:30];
                    r_cz <= {{(MUL_W-32){w_z32[31]}}, w_z32};
                    r_cx <= {{(MUL_W-32){1'b0}}, CORDIC_GAIN_Q30};
                    r_cy <= '0;
                end
                PH_RPM: begin
                    for (int k = 0; k < 2; k++) begin
                        r_err[k] <= w_err[k];
                    end
                end
                PH_GAIN: begin
                    for (int k = 0; k < 2; k++) begin
                        r_mag[k] <= w_mag[k];
                    end
                end
                PH_PER: begin
                    for (int k = 0; k < 2; k++) begin
                        r_dv[k]  <= w_p[k][LIM_W+15:16];
                        r_rem[k] <= '0;
                    end
                end
                default: ;
            endcase
        end
        if (r_state == ST_DIV) begin
            for (int k = 0; k < 2; k++) begin
                r_rem[k] <= w_ge[k] ? REM_W'(w_rsh[k] - PCT_SCALE) : w_rsh[k][REM_W-1:0];
                r_dv[k]  <= {r_dv[k][LIM_W-2:0], w_ge[k]};
            end
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_o_x    <= r_px;
            r_o_y    <= r_py;
            r_o_head <= r_head;
            for (int k = 0; k < 2; k++) begin
                r_o_duty[k] <= (|r_dv[k][LIM_W-1:16]) ? 16'hFFFF : r_dv[k][15:0];
                if (r_err[k] == '0) begin
                    r_o_dir[k] <= DIR_STOP;
                end else if (r_err[k][ERR_W-1]) begin
                    r_o_dir[k] <= DIR_REV;
                end else begin
                    r_o_dir[k] <= DIR_FWD;
                end
            end
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_pose_x     = r_o_x;
    assign o_pose_y     = r_o_y;
    assign o_heading    = r_o_head;
    assign o_left_duty  = r_o_duty[0];
    assign o_right_duty = r_o_duty[1];
    assign o_left_dir   = r_o_dir[0];
    assign o_right_dir  = r_o_dir[1];

    a_accept_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_LAUNCH))
        else $error("accepted transaction did not launch");

    a_mul_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy0 == w_busy1)
        else $error("multipliers out of step");

    a_mul_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy0 |-> (r_state == ST_MUL))
        else $error("multiplier busy outside multiply state");

    a_cordic_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ccnt <= CC_W'(CORDIC_N))
        else $error("CORDIC step count overrun");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_dcnt < DCNT_W'(LIM_W)))
        else $error("divider count overrun");

endmodule

[sv/ddo_serial_mul.sv]
// Signed bit-serial multiplier: one multiplier bit per cycle.
// Multiplicand held in parallel, product shifts right through a hi/lo pair.
// Depends on ddo_pkg.
module ddo_serial_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  ddo_pkg::t_mop                i_a,
    input  ddo_pkg::t_mop                i_b,
    output logic                         o_busy,
    output logic [ddo_pkg::PROD_W-1:0]   o_prod
);
    import ddo_pkg::*;

    logic [MUL_W-1:0]  r_a;
    logic [MUL_W-1:0]  r_h;
    logic [MUL_W-1:0]  r_l;
    logic [MCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic [MUL_W:0]    w_add;
    logic [MUL_W:0]    w_sum;

    always_comb begin
        if (r_l[0]) begin
            if (r_cnt == MCNT_W'(MUL_W - 1)) begin
                w_add = -{r_a[MUL_W-1], r_a};
            end else begin
                w_add = {r_a[MUL_W-1], r_a};
            end
        end else begin
            w_add = '0;
        end
        w_sum = {r_h[MUL_W-1], r_h} + w_add;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + MCNT_W'(1);
            if (r_cnt == MCNT_W'(MUL_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_h <= '0;
            r_l <= i_b;
        end else if (r_busy) begin
            r_h <= w_sum[MUL_W:1];
            r_l <= {w_sum[0], r_l[MUL_W-1:1]};
        end
    end

    assign o_busy = r_busy;
    assign o_prod = {r_h, r_l};

endmodule
